### rtl/skt_pkg.sv
`default_nettype none
package skt_pkg;

  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_REMOVE_KEY = 3'd1;
  localparam logic [2:0] OP_FIND       = 3'd2;
  localparam logic [2:0] OP_READ_POS   = 3'd3;
  localparam logic [2:0] OP_REMOVE_POS = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] ORDER_NONE = 2'd0;
  localparam logic [1:0] ORDER_ASC  = 2'd1;
  localparam logic [1:0] ORDER_DESC = 2'd2;

  localparam int GRP_W     = 8;
  localparam int GRP_LOC_W = 3;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE
  } cell_cmd_t;

  typedef struct packed {
    logic      sample;
    logic      ascending;
    logic      occupied;
    cell_cmd_t cmd;
    logic      at;
    logic      after;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GRP,
    S_SEL,
    S_EXEC
  } state_t;

endpackage
`default_nettype wire

### rtl/skt_cell.sv
`default_nettype none
module skt_cell #(
  parameter int KEY_BITS  = 64,
  parameter int DATA_BITS = 32
) (
  input  wire                       clk,
  input  skt_pkg::cell_ctrl_t       ctrl,
  input  wire  [KEY_BITS-1:0]       cmp_key,
  input  wire  [KEY_BITS-1:0]       new_key,
  input  wire  [DATA_BITS-1:0]      new_data,
  input  wire  [KEY_BITS-1:0]       prev_key,
  input  wire  [DATA_BITS-1:0]      prev_data,
  input  wire  [KEY_BITS-1:0]       next_key,
  input  wire  [DATA_BITS-1:0]      next_data,
  output logic [KEY_BITS-1:0]       key,
  output logic [DATA_BITS-1:0]      data,
  output logic                      match,
  output logic                      not_before
);

  logic ahead;

  assign ahead = ctrl.ascending ? (key < cmp_key) : (key > cmp_key);

  always_ff @(posedge clk) begin
    if (ctrl.sample) begin
      match      <= ctrl.occupied && (key == cmp_key);
      not_before <= ctrl.occupied && !ahead;
    end
    case (ctrl.cmd)
      skt_pkg::CMD_INSERT: begin
        if (ctrl.at) begin
          key  <= new_key;
          data <= new_data;
        end else if (ctrl.after) begin
          key  <= prev_key;
          data <= prev_data;
        end
      end
      skt_pkg::CMD_REMOVE: begin
        if (ctrl.at || ctrl.after) begin
          key  <= next_key;
          data <= next_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/skt_grp_enc.sv
`default_nettype none
module skt_grp_enc (
  input  wire                            clk,
  input  wire  [skt_pkg::GRP_W-1:0]      flags,
  output logic                           any,
  output logic [skt_pkg::GRP_LOC_W-1:0]  loc
);

  logic                          any_c;
  logic [skt_pkg::GRP_LOC_W-1:0] loc_c;

  // lowest set flag wins
  always_comb begin
    any_c = 1'b0;
    loc_c = '0;
    for (int i = skt_pkg::GRP_W - 1; i >= 0; i--) begin
      if (flags[i]) begin
        any_c = 1'b1;
        loc_c = skt_pkg::GRP_LOC_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    any <= any_c;
    loc <= loc_c;
  end

endmodule
`default_nettype wire

### rtl/sorted_key_table.sv
`default_nettype none
// sorted_key_table: up to DEPTH key/data entries kept in key order
// (ascending, descending or arrival order as sort_order selects).
// input channel: in_valid/in_ready carry opcode, key, entry_data, position.
// output channel: out_valid/out_ready carry status, found_index, found_data
// and entry_count, one result per accepted item.
// cfg_wr_en/cfg_wr_data write sort_order; write it only while no item is in flight.
// every entry sits in its own cell; all cells compare against the key in
// the cycle of the transfer, the match flags pass a registered priority
// encoder in groups of eight, then the first index is picked and the entries
// from that index onward shift by one place together for insert or remove.
// the item passes the sampled flags, the group encoder registers, the select
// registers and then the result register; in_ready is high only while the
// block holds no item in flight, so no new item is taken before the last is done.
// if a held result is not taken (out_ready low) the finished item waits in
// the last step, the table is not changed until the result register frees up.
// reset: entry count zero, sort_order ascending, no result pending;
// entry contents are left as they are.
module sorted_key_table #(
  parameter int DEPTH     = 256,
  parameter int KEY_BITS  = 64,
  parameter int DATA_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [1:0]  cfg_wr_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  opcode,
  input  wire  [63:0] key,
  input  wire  [31:0] entry_data,
  input  wire  [7:0]  position,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  status,
  output logic [7:0]  found_index,
  output logic [31:0] found_data,
  output logic [8:0]  entry_count
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int NGRP  = (DEPTH + skt_pkg::GRP_W - 1) / skt_pkg::GRP_W;
  localparam int NPAD  = NGRP * skt_pkg::GRP_W;

  skt_pkg::state_t state, state_next;

  logic [1:0]           sort_order;
  logic [CNT_W-1:0]     count;
  logic [2:0]           req_op;
  logic [KEY_BITS-1:0]  req_key;
  logic [DATA_BITS-1:0] req_data;
  logic [7:0]           req_pos;

  logic [1:0]           ex_status;
  logic [IDX_W-1:0]     ex_idx;
  logic [7:0]           ex_fidx;
  logic                 ex_want_data;
  skt_pkg::cell_cmd_t   ex_cmd;
  logic [CNT_W-1:0]     ex_count;

  logic [1:0]           sel_status;
  logic [IDX_W-1:0]     sel_idx;
  logic [7:0]           sel_fidx;
  logic                 sel_want_data;
  skt_pkg::cell_cmd_t   sel_cmd;
  logic [CNT_W-1:0]     sel_count;

  logic                 accept;
  logic                 out_free;
  logic                 commit;
  logic                 sorted;
  logic                 full;
  skt_pkg::cell_cmd_t   live_cmd;

  logic [KEY_BITS-1:0]  cell_key  [DEPTH];
  logic [DATA_BITS-1:0] cell_data [DEPTH];
  logic [NPAD-1:0]      m_flag;
  logic [NPAD-1:0]      i_flag;
  logic [NGRP-1:0]      m_any;
  logic [NGRP-1:0]      i_any;
  logic [skt_pkg::GRP_LOC_W-1:0] m_loc [NGRP];
  logic [skt_pkg::GRP_LOC_W-1:0] i_loc [NGRP];

  logic                 m_hit, i_hit;
  logic [IDX_W-1:0]     m_idx, i_idx;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == skt_pkg::S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign commit   = (state == skt_pkg::S_EXEC) && out_free;
  assign live_cmd = commit ? ex_cmd : skt_pkg::CMD_HOLD;
  assign sorted   = (sort_order == skt_pkg::ORDER_ASC) || (sort_order == skt_pkg::ORDER_DESC);
  assign full     = (count == CNT_W'(DEPTH));

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      skt_pkg::cell_ctrl_t  ctrl;
      logic [KEY_BITS-1:0]  pk, nk;
      logic [DATA_BITS-1:0] pd, nd;

      assign ctrl.sample    = accept;
      assign ctrl.ascending = (sort_order == skt_pkg::ORDER_ASC);
      assign ctrl.occupied  = CNT_W'(gi) < count;
      assign ctrl.cmd       = live_cmd;
      assign ctrl.at        = (IDX_W'(gi) == ex_idx);
      assign ctrl.after     = (IDX_W'(gi) > ex_idx);

      if (gi == 0) begin : g_first
        assign pk = '0;
        assign pd = '0;
      end else begin : g_mid
        assign pk = cell_key[gi-1];
        assign pd = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign nk = '0;
        assign nd = '0;
      end else begin : g_body
        assign nk = cell_key[gi+1];
        assign nd = cell_data[gi+1];
      end

      skt_cell #(
        .KEY_BITS (KEY_BITS),
        .DATA_BITS(DATA_BITS)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .cmp_key   (KEY_BITS'(key)),
        .new_key   (req_key),
        .new_data  (req_data),
        .prev_key  (pk),
        .prev_data (pd),
        .next_key  (nk),
        .next_data (nd),
        .key       (cell_key[gi]),
        .data      (cell_data[gi]),
        .match     (m_flag[gi]),
        .not_before(i_flag[gi])
      );
    end

    if (NPAD > DEPTH) begin : g_pad
      assign m_flag[NPAD-1:DEPTH] = '0;
      assign i_flag[NPAD-1:DEPTH] = '0;
    end

    for (gi = 0; gi < NGRP; gi++) begin : g_grp
      skt_grp_enc u_m_enc (
        .clk  (clk),
        .flags(m_flag[gi*skt_pkg::GRP_W +: skt_pkg::GRP_W]),
        .any  (m_any[gi]),
        .loc  (m_loc[gi])
      );
      skt_grp_enc u_i_enc (
        .clk  (clk),
        .flags(i_flag[gi*skt_pkg::GRP_W +: skt_pkg::GRP_W]),
        .any  (i_any[gi]),
        .loc  (i_loc[gi])
      );
    end
  endgenerate

  // first group with a hit
  always_comb begin
    m_hit = 1'b0;
    i_hit = 1'b0;
    m_idx = '0;
    i_idx = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (m_any[g]) begin
        m_hit = 1'b1;
        m_idx = IDX_W'(g * skt_pkg::GRP_W) + IDX_W'(m_loc[g]);
      end
      if (i_any[g]) begin
        i_hit = 1'b1;
        i_idx = IDX_W'(g * skt_pkg::GRP_W) + IDX_W'(i_loc[g]);
      end
    end
  end

  always_comb begin
    sel_status    = skt_pkg::ST_OK;
    sel_idx       = '0;
    sel_fidx      = '0;
    sel_want_data = 1'b0;
    sel_cmd       = skt_pkg::CMD_HOLD;
    sel_count     = count;
    case (req_op)
      skt_pkg::OP_INSERT: begin
        if (full) begin
          sel_status = skt_pkg::ST_FULL;
        end else begin
          sel_idx   = (sorted && i_hit) ? i_idx : IDX_W'(count);
          sel_fidx  = 8'(sel_idx);
          sel_cmd   = skt_pkg::CMD_INSERT;
          sel_count = count + CNT_W'(1);
        end
      end
      skt_pkg::OP_REMOVE_KEY, skt_pkg::OP_FIND: begin
        if (!sorted || !m_hit) begin
          sel_status = skt_pkg::ST_NOT_FOUND;
        end else begin
          sel_idx  = m_idx;
          sel_fidx = 8'(m_idx);
          if (req_op == skt_pkg::OP_REMOVE_KEY) begin
            sel_want_data = 1'b1;
            sel_cmd       = skt_pkg::CMD_REMOVE;
            sel_count     = count - CNT_W'(1);
          end
        end
      end
      skt_pkg::OP_READ_POS, skt_pkg::OP_REMOVE_POS: begin
        if (CMP_W'(req_pos) >= CMP_W'(count)) begin
          sel_status = skt_pkg::ST_NOT_FOUND;
        end else begin
          sel_idx       = IDX_W'(req_pos);
          sel_fidx      = req_pos;
          sel_want_data = 1'b1;
          if (req_op == skt_pkg::OP_REMOVE_POS) begin
            sel_cmd   = skt_pkg::CMD_REMOVE;
            sel_count = count - CNT_W'(1);
          end
        end
      end
      skt_pkg::OP_CLEAR: begin
        sel_count = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      skt_pkg::S_IDLE: if (accept) state_next = skt_pkg::S_GRP;
      skt_pkg::S_GRP:  state_next = skt_pkg::S_SEL;
      skt_pkg::S_SEL:  state_next = skt_pkg::S_EXEC;
      skt_pkg::S_EXEC: if (out_free) state_next = skt_pkg::S_IDLE;
      default:         state_next = skt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_order <= skt_pkg::ORDER_ASC;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sort_order <= cfg_wr_data;
      end
      if (commit) begin
        count     <= ex_count;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= opcode;
      req_key  <= KEY_BITS'(key);
      req_data <= DATA_BITS'(entry_data);
      req_pos  <= position;
    end
    if (state == skt_pkg::S_SEL) begin
      ex_status    <= sel_status;
      ex_idx       <= sel_idx;
      ex_fidx      <= sel_fidx;
      ex_want_data <= sel_want_data;
      ex_cmd       <= sel_cmd;
      ex_count     <= sel_count;
    end
    if (commit) begin
      status      <= ex_status;
      found_index <= ex_fidx;
      found_data  <= ex_want_data ? 32'(cell_data[ex_idx]) : 32'd0;
      entry_count <= 9'(ex_count);
    end
  end

endmodule
`default_nettype wire

### rtl/skt_checker.sv
`default_nettype none
module skt_checker #(
  parameter int DEPTH = 256
) (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  status,
  input wire [7:0]  found_index,
  input wire [31:0] found_data,
  input wire [8:0]  entry_count
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_index)
      && $stable(found_data) && $stable(entry_count))
    else $error("result changed while stalled");

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == skt_pkg::ST_FULL) |-> entry_count == 9'(DEPTH))
    else $error("full status with room left");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending after reset");

endmodule

bind sorted_key_table skt_checker #(.DEPTH(DEPTH)) u_skt_checker (.*);
`default_nettype wire
